### sv/iwrm_pkg.sv
package iwrm_pkg;

	localparam int TICK_W = 63;
	localparam int IVAL_W = 48;
	localparam int FREQ_W = 40;
	localparam int RATE_W = 32;
	localparam int FRAC_W = 16;
	localparam int STEP_W = 5;

	localparam logic [FREQ_W-1:0] FREQ_RESET = 40'd1000000000;
	localparam logic [RATE_W-1:0] RATE_MAX = '1;
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(RATE_W - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUB,
		ST_ADD,
		ST_DIV,
		ST_WAIT,
		ST_OUT
	} mtr_state_t;

	typedef enum logic [1:0] {
		DV_IDLE,
		DV_CHK,
		DV_RUN,
		DV_DONE
	} div_state_t;

	typedef struct packed {
		logic              done;
		logic [RATE_W-1:0] quot;
	} div_res_t;

endpackage

### sv/iwrm_ram.sv
module iwrm_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 100
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### sv/iwrm_div.sv
module iwrm_div #(
	parameter int NUM_W = 47,
	parameter int DEN_W = 55
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [NUM_W-1:0]     num,
	input  logic [DEN_W-1:0]     den,
	output iwrm_pkg::div_res_t   res
);

	localparam int CMP_W = DEN_W + iwrm_pkg::FRAC_W;

	iwrm_pkg::div_state_t state_q, state_d;

	logic [NUM_W-1:0]            num_q;
	logic [DEN_W-1:0]            den_q;
	logic [DEN_W-1:0]            rem_q;
	logic [iwrm_pkg::RATE_W-1:0] lo_q;
	logic [iwrm_pkg::STEP_W-1:0] step_q;

	logic                        zero_case;
	logic                        sat_case;
	logic [DEN_W:0]              trial;
	logic                        fits;

	// The quotient of num * 2^16 / den saturates exactly when num >= den * 2^16.
	assign zero_case = (den_q == '0) && (num_q == '0);
	assign sat_case  = CMP_W'(num_q) >= {den_q, {iwrm_pkg::FRAC_W{1'b0}}};

	assign trial = {rem_q, lo_q[iwrm_pkg::RATE_W-1]} - {1'b0, den_q};
	assign fits  = !trial[DEN_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= iwrm_pkg::DV_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			iwrm_pkg::DV_IDLE: begin
				if (start) begin
					state_d = iwrm_pkg::DV_CHK;
				end
			end
			iwrm_pkg::DV_CHK: begin
				if (zero_case || sat_case) begin
					state_d = iwrm_pkg::DV_DONE;
				end else begin
					state_d = iwrm_pkg::DV_RUN;
				end
			end
			iwrm_pkg::DV_RUN: begin
				if (step_q == iwrm_pkg::LAST_STEP) begin
					state_d = iwrm_pkg::DV_DONE;
				end
			end
			iwrm_pkg::DV_DONE: begin
				state_d = iwrm_pkg::DV_IDLE;
			end
			default: begin
				state_d = iwrm_pkg::DV_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			iwrm_pkg::DV_IDLE: begin
				if (start) begin
					num_q <= num;
					den_q <= den;
				end
			end
			iwrm_pkg::DV_CHK: begin
				step_q <= '0;
				if (zero_case) begin
					lo_q <= '0;
				end else if (sat_case) begin
					lo_q <= iwrm_pkg::RATE_MAX;
				end else begin
					// Upper dividend bits start as the remainder; they are below den here.
					rem_q <= DEN_W'(num_q >> iwrm_pkg::FRAC_W);
					lo_q  <= {num_q[iwrm_pkg::FRAC_W-1:0], {iwrm_pkg::FRAC_W{1'b0}}};
				end
			end
			iwrm_pkg::DV_RUN: begin
				if (fits) begin
					rem_q <= trial[DEN_W-1:0];
				end else begin
					rem_q <= {rem_q[DEN_W-2:0], lo_q[iwrm_pkg::RATE_W-1]};
				end
				lo_q   <= {lo_q[iwrm_pkg::RATE_W-2:0], fits};
				step_q <= step_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign res.done = (state_q == iwrm_pkg::DV_DONE);
	assign res.quot = lo_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		start |-> state_q == iwrm_pkg::DV_IDLE)
		else $error("divider started while busy");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == iwrm_pkg::DV_CHK && zero_case |=> res.done && res.quot == '0)
		else $error("zero frequency over zero sum must give zero");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == iwrm_pkg::DV_RUN && step_q != iwrm_pkg::LAST_STEP |=>
		state_q == iwrm_pkg::DV_RUN)
		else $error("division left early");

endmodule

### sv/interval_window_rate_meter_core.sv
// The first event after reset goes straight to the output; later events run the divider,
// which skips its steps when the rate saturates or the interval sum is zero; else the 32
// quotient bits come one a cycle from a shared subtractor. A new event is taken only in
// ST_IDLE, once the last result has been moved into the output register.
// Reset clears the timestamp, interval sum, fill count and ring pointer and loads
// tick_frequency with 1000000000; ring entries are never cleared, the fill count masks them.
module interval_window_rate_meter_core #(
	parameter int WINDOW = 100
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [62:0] tick
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] rate_q16
	output logic [0:0]  m_tuser,   // [0] rate_valid
	input  logic        cfg_we,
	input  logic [39:0] cfg_wdata
);

	localparam int PTR_W = $clog2(WINDOW);
	localparam int CNT_W = $clog2(WINDOW + 1);
	localparam int SUM_W = iwrm_pkg::IVAL_W + PTR_W;
	localparam int NUM_W = iwrm_pkg::FREQ_W + CNT_W;

	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(WINDOW);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW - 1);

	iwrm_pkg::mtr_state_t state_q, state_d;

	logic [iwrm_pkg::FREQ_W-1:0] tick_frequency_q;
	logic [iwrm_pkg::TICK_W-1:0] last_tick_q;
	logic                        started_q;
	logic [iwrm_pkg::IVAL_W-1:0] ival_q;
	logic [SUM_W-1:0]            sum_q;
	logic [CNT_W-1:0]            n_q;
	logic [PTR_W-1:0]            ptr_q;
	logic [NUM_W-1:0]            prod_q;
	logic [iwrm_pkg::RATE_W-1:0] res_rate_q;
	logic                        res_valid_q;
	logic                        m_tvalid_q;
	logic [iwrm_pkg::RATE_W-1:0] m_rate_q;
	logic                        m_flag_q;

	logic [iwrm_pkg::TICK_W-1:0] tick_in;
	logic [iwrm_pkg::TICK_W-1:0] diff;
	logic [iwrm_pkg::IVAL_W-1:0] ival_sat;
	logic [iwrm_pkg::IVAL_W-1:0] ram_rd;
	logic [iwrm_pkg::IVAL_W-1:0] old_ival;
	logic                        full;
	logic [CNT_W-1:0]            n_next;
	logic                        in_xfer;
	logic                        out_free;
	logic                        div_start;
	iwrm_pkg::div_res_t          div_res;

	assign tick_in  = s_tdata[iwrm_pkg::TICK_W-1:0];
	assign diff     = tick_in - last_tick_q;
	assign ival_sat = (|diff[iwrm_pkg::TICK_W-1:iwrm_pkg::IVAL_W]) ? '1
		: diff[iwrm_pkg::IVAL_W-1:0];

	// Slots are written in order, so until the ring is full the slot under the
	// pointer has never been written and counts as zero.
	assign full     = (n_q == CNT_FULL);
	assign old_ival = full ? ram_rd : '0;
	assign n_next   = full ? n_q : n_q + 1'b1;

	assign s_tready  = (state_q == iwrm_pkg::ST_IDLE);
	assign in_xfer   = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q || m_tready;
	assign div_start = (state_q == iwrm_pkg::ST_DIV);

	iwrm_ram #(
		.WIDTH(iwrm_pkg::IVAL_W),
		.DEPTH(WINDOW)
	) u_ring (
		.clk  (clk),
		.we   (state_q == iwrm_pkg::ST_ADD),
		.waddr(ptr_q),
		.wdata(ival_q),
		.raddr(ptr_q),
		.rdata(ram_rd)
	);

	iwrm_div #(
		.NUM_W(NUM_W),
		.DEN_W(SUM_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (prod_q),
		.den   (sum_q),
		.res   (div_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= iwrm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			iwrm_pkg::ST_IDLE: begin
				if (in_xfer) begin
					state_d = started_q ? iwrm_pkg::ST_SUB : iwrm_pkg::ST_OUT;
				end
			end
			iwrm_pkg::ST_SUB:  state_d = iwrm_pkg::ST_ADD;
			iwrm_pkg::ST_ADD:  state_d = iwrm_pkg::ST_DIV;
			iwrm_pkg::ST_DIV:  state_d = iwrm_pkg::ST_WAIT;
			iwrm_pkg::ST_WAIT: begin
				if (div_res.done) begin
					state_d = iwrm_pkg::ST_OUT;
				end
			end
			iwrm_pkg::ST_OUT: begin
				if (out_free) begin
					state_d = iwrm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = iwrm_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_frequency_q <= iwrm_pkg::FREQ_RESET;
			last_tick_q      <= '0;
			started_q        <= 1'b0;
			sum_q            <= '0;
			n_q              <= '0;
			ptr_q            <= '0;
			m_tvalid_q       <= 1'b0;
		end else begin
			if (cfg_we) begin
				tick_frequency_q <= cfg_wdata;
			end
			if (in_xfer) begin
				last_tick_q <= tick_in;
				started_q   <= 1'b1;
			end
			if (state_q == iwrm_pkg::ST_SUB) begin
				sum_q <= sum_q - SUM_W'(old_ival);
			end
			if (state_q == iwrm_pkg::ST_ADD) begin
				sum_q <= sum_q + SUM_W'(ival_q);
				n_q   <= n_next;
				ptr_q <= (ptr_q == PTR_LAST) ? '0 : ptr_q + 1'b1;
			end
			if (state_q == iwrm_pkg::ST_OUT && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			ival_q      <= ival_sat;
			res_rate_q  <= '0;
			res_valid_q <= 1'b0;
		end
		if (state_q == iwrm_pkg::ST_ADD) begin
			prod_q <= NUM_W'(tick_frequency_q) * NUM_W'(n_next);
		end
		if (state_q == iwrm_pkg::ST_WAIT && div_res.done) begin
			res_rate_q  <= div_res.quot;
			res_valid_q <= 1'b1;
		end
		if (state_q == iwrm_pkg::ST_OUT && out_free) begin
			m_rate_q <= res_rate_q;
			m_flag_q <= res_valid_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_rate_q;
	assign m_tuser  = m_flag_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> !s_tready)
		else $error("input taken while an event is in progress");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == '0)
		else $error("invalid rate must read zero");

	assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= CNT_FULL && ptr_q <= PTR_LAST)
		else $error("fill count or ring pointer out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		div_res.done |-> state_q == iwrm_pkg::ST_WAIT)
		else $error("divider finished with no event waiting");

	assert property (@(posedge clk) disable iff (!arst_n)
		!full |-> ptr_q == PTR_W'(n_q))
		else $error("ring pointer lost track of the fill count");

endmodule
